FILE: rtl/core/htx_pkg.sv
// ----------------------------------------------------------------------------
// htx_pkg
// Shared types and constants of the HDLC transmit framer: controller states,
// emit kinds, the command and status groups and the framing constants.
// ----------------------------------------------------------------------------
package htx_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 512;
  localparam int unsigned POS_W           = 10;
  localparam int unsigned CNT_W           = POS_W + 1;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 3;

  localparam logic [CNT_W-1:0] LEN_LIMIT = CNT_W'(MAX_FRAME_BYTES - 2);
  localparam logic [CNT_W-1:0] LEN_MIN   = CNT_W'(16);
  localparam logic [POS_W-1:0] SSID_POS_A = POS_W'(6);
  localparam logic [POS_W-1:0] SSID_POS_B = POS_W'(13);

  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [7:0]  SSID_MASK = 8'h1F;
  localparam logic [7:0]  SSID_SET  = 8'hE0;
  // Flag 0x7E; bit b of this word is the b-th bit on the line.
  localparam logic [7:0]  FLAG_PATTERN = 8'b0111_1110;
  localparam logic [2:0]  STUFF_RUN    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSING  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_DATA,
    ST_FCS_LO,
    ST_FCS_HI,
    ST_CLOSE,
    ST_ERR
  } ctrl_state_t;

  typedef enum logic [1:0] {
    EM_PRE,
    EM_CLOSE,
    EM_SER,
    EM_ERR
  } emit_kind_t;

  typedef struct packed {
    logic       accept;
    logic       emit;
    emit_kind_t kind;
    logic       fold_crc;
    logic       load_fcs_lo;
    logic       load_fcs_hi;
    logic       close;
  } ctrl_cmd_t;

  typedef struct packed {
    logic over;
    logic short_frame;
    logic first_byte;
    logic in_fin;
    logic fin;
    logic can_emit;
    logic flag_done;
    logic ser_done;
  } dp_status_t;

endpackage

FILE: rtl/core/htx_if.sv
// ----------------------------------------------------------------------------
// htx_in_if / htx_out_if
// Valid/ready channels of the framer: frame bytes in, line bits out.
// ----------------------------------------------------------------------------
interface htx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       final_byte;

  modport source (output valid, output frame_byte, output final_byte, input ready);
  modport sink   (input valid, input frame_byte, input final_byte, output ready);
endinterface

interface htx_out_if;
  logic valid;
  logic ready;
  logic line_bit;
  logic end_of_frame;
  logic length_error;

  modport source (output valid, output line_bit, output end_of_frame,
                  output length_error, input ready);
  modport sink   (input valid, input line_bit, input end_of_frame,
                  input length_error, output ready);
endinterface

FILE: rtl/core/hdlc_tx_framer_crc_bitstuff.sv
// ----------------------------------------------------------------------------
// hdlc_tx_framer_crc_bitstuff
// AX.25 / HDLC transmit framer with CRC-16 (X.25 FCS) and zero-bit stuffing.
// ----------------------------------------------------------------------------
// Frame bytes enter on in_chan, one per transfer, with final_byte set on the
// last byte of a frame. Line bits leave on out_chan, one per transfer, ahead
// of an NRZI coder. The first byte of a frame is preceded by the preamble
// flags; the last byte is followed by the inverted FCS and the closing flags,
// and end_of_frame marks the last closing-flag bit. A frame shorter than 16
// bytes, or longer than MAX_FRAME_BYTES-2, ends in one error transfer instead.
// The cfg_ port writes the preamble flag count (index 0) and the closing flag
// count (index 1). Write it only while the framer is idle; the block itself
// does not enforce this. A byte is taken while the sequencer is idle; the
// sequencer state is registered, and the first bit that follows then goes
// into the output register. The bit sequencer sends one line bit per cycle
// unless the receiver stalls. One byte is in work at a time. When the
// receiver stalls, the output register holds its bit and the sequencer
// waits. Reset empties the output register, closes any open frame and sets
// both flag counts to 1.
// ----------------------------------------------------------------------------
module hdlc_tx_framer_crc_bitstuff (
  input  logic                           clk,
  input  logic                           rst_n,
  htx_in_if.sink                         in_chan,
  htx_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [htx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [htx_pkg::CFG_DATA_W-1:0] cfg_data
);

  htx_pkg::ctrl_cmd_t  cmd;
  htx_pkg::dp_status_t sts;

  // The sequencer owns the phase of the frame and the input handshake.
  htx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath keeps the CRC, the stuffing run, the byte position and the
  // output register that decouples the sequencer from a stalling receiver.
  htx_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_frame_byte    (in_chan.frame_byte),
    .in_final_byte    (in_chan.final_byte),
    .cmd              (cmd),
    .sts              (sts),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_line_bit     (out_chan.line_bit),
    .out_end_of_frame (out_chan.end_of_frame),
    .out_length_error (out_chan.length_error)
  );

endmodule

FILE: rtl/core/htx_ctrl.sv
// ----------------------------------------------------------------------------
// htx_ctrl
// Sequencer of the framer: walks preamble, data, FCS and closing phases, or sends the error transfer.
// ----------------------------------------------------------------------------
module htx_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  htx_pkg::dp_status_t sts,
  output htx_pkg::ctrl_cmd_t  cmd
);

  htx_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= htx_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.kind        = htx_pkg::EM_SER;
    case (state_r)
      htx_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          if (sts.over) begin
            if (sts.in_fin) state_nxt = htx_pkg::ST_ERR;
          end else if (sts.short_frame) begin
            state_nxt = htx_pkg::ST_ERR;
          end else if (sts.first_byte) begin
            state_nxt = htx_pkg::ST_PRE;
          end else begin
            state_nxt = htx_pkg::ST_DATA;
          end
        end
      end
      htx_pkg::ST_PRE: begin
        if (sts.can_emit) begin
          cmd.emit = 1'b1;
          cmd.kind = htx_pkg::EM_PRE;
          if (sts.flag_done) state_nxt = htx_pkg::ST_DATA;
        end
      end
      htx_pkg::ST_DATA: begin
        if (sts.can_emit) begin
          cmd.emit     = 1'b1;
          cmd.kind     = htx_pkg::EM_SER;
          cmd.fold_crc = 1'b1;
          if (sts.ser_done) begin
            if (sts.fin) begin
              cmd.load_fcs_lo = 1'b1;
              state_nxt       = htx_pkg::ST_FCS_LO;
            end else begin
              state_nxt = htx_pkg::ST_IDLE;
            end
          end
        end
      end
      htx_pkg::ST_FCS_LO: begin
        if (sts.can_emit) begin
          cmd.emit = 1'b1;
          cmd.kind = htx_pkg::EM_SER;
          if (sts.ser_done) begin
            cmd.load_fcs_hi = 1'b1;
            state_nxt       = htx_pkg::ST_FCS_HI;
          end
        end
      end
      htx_pkg::ST_FCS_HI: begin
        if (sts.can_emit) begin
          cmd.emit = 1'b1;
          cmd.kind = htx_pkg::EM_SER;
          if (sts.ser_done) state_nxt = htx_pkg::ST_CLOSE;
        end
      end
      htx_pkg::ST_CLOSE: begin
        if (sts.can_emit) begin
          cmd.emit = 1'b1;
          cmd.kind = htx_pkg::EM_CLOSE;
          if (sts.flag_done) begin
            cmd.close = 1'b1;
            state_nxt = htx_pkg::ST_IDLE;
          end
        end
      end
      htx_pkg::ST_ERR: begin
        if (sts.can_emit) begin
          cmd.emit  = 1'b1;
          cmd.kind  = htx_pkg::EM_ERR;
          cmd.close = 1'b1;
          state_nxt = htx_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = htx_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/htx_datapath.sv
// ----------------------------------------------------------------------------
// htx_datapath
// Frame state, serial CRC, bit stuffer, flag generator and output register.
// ----------------------------------------------------------------------------
module htx_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [htx_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [htx_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [7:0]                            in_frame_byte,
  input  logic                                  in_final_byte,
  input  htx_pkg::ctrl_cmd_t                    cmd,
  output htx_pkg::dp_status_t                   sts,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic                                  out_line_bit,
  output logic                                  out_end_of_frame,
  output logic                                  out_length_error
);

  logic [2:0]                  pre_cnt_r;
  logic [1:0]                  clo_cnt_r;
  logic [15:0]                 crc_r, crc_nxt;
  logic [2:0]                  ones_r, ones_nxt;
  logic                        pend_r, pend_nxt;
  logic [htx_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic                        ovf_r, ovf_nxt;
  logic [2:0]                  bit_cnt_r, bit_cnt_nxt;
  logic [1:0]                  flag_cnt_r, flag_cnt_nxt;
  logic [7:0]                  sh_r, sh_nxt;
  logic                        fin_r, fin_nxt;
  logic                        valid_r, valid_nxt;
  logic                        bit_r, bit_nxt;
  logic                        eof_r, eof_nxt;
  logic                        err_r, err_nxt;

  logic [htx_pkg::CNT_W-1:0]   count;
  logic [1:0]                  pre_last, clo_last;
  logic                        flag_last;
  logic                        ser_bit;
  logic                        fb;

  assign count = {1'b0, pos_r} + htx_pkg::CNT_W'(1);

  // Out-of-range flag counts are clamped into 1..4 and 1..2.
  always_comb begin
    if (pre_cnt_r == 3'd0)      pre_last = 2'd0;
    else if (pre_cnt_r > 3'd4)  pre_last = 2'd3;
    else                        pre_last = 2'(pre_cnt_r - 3'd1);
    if (clo_cnt_r == 2'd0)      clo_last = 2'd0;
    else if (clo_cnt_r > 2'd2)  clo_last = 2'd1;
    else                        clo_last = clo_cnt_r - 2'd1;
  end

  // Preamble flags only precede a byte that is not final, and closing flags
  // only follow a final byte, so the held final mark picks the flag count.
  assign flag_last = fin_r ? (flag_cnt_r == clo_last) : (flag_cnt_r == pre_last);
  assign ser_bit   = sh_r[0];
  assign fb        = crc_r[0] ^ ser_bit;

  always_comb begin
    sts.over        = ovf_r || (count > htx_pkg::LEN_LIMIT);
    sts.short_frame = in_final_byte && (count < htx_pkg::LEN_MIN);
    sts.first_byte  = (pos_r == '0);
    sts.in_fin      = in_final_byte;
    sts.fin         = fin_r;
    sts.can_emit    = !valid_r || out_ready;
    sts.flag_done   = (bit_cnt_r == 3'd7) && flag_last;
    sts.ser_done    = pend_r ? (bit_cnt_r == 3'd0)
                             : ((bit_cnt_r == 3'd7) &&
                                !(ser_bit && (ones_r == htx_pkg::STUFF_RUN - 3'd1)));
  end

  always_comb begin
    crc_nxt      = crc_r;
    ones_nxt     = ones_r;
    pend_nxt     = pend_r;
    pos_nxt      = pos_r;
    ovf_nxt      = ovf_r;
    bit_cnt_nxt  = bit_cnt_r;
    flag_cnt_nxt = flag_cnt_r;
    sh_nxt       = sh_r;
    fin_nxt      = fin_r;
    valid_nxt    = valid_r && !out_ready;
    bit_nxt      = bit_r;
    eof_nxt      = eof_r;
    err_nxt      = err_r;

    if (cmd.accept) begin
      fin_nxt = in_final_byte;
      if ((pos_r == htx_pkg::SSID_POS_A) || (pos_r == htx_pkg::SSID_POS_B)) begin
        sh_nxt = (in_frame_byte & htx_pkg::SSID_MASK) | htx_pkg::SSID_SET;
      end else begin
        sh_nxt = in_frame_byte;
      end
      if (sts.over) begin
        ovf_nxt = 1'b1;
      end else if (!sts.short_frame) begin
        pos_nxt = count[htx_pkg::POS_W-1:0];
      end
    end

    if (cmd.emit) begin
      valid_nxt = 1'b1;
      eof_nxt   = 1'b0;
      err_nxt   = 1'b0;
      case (cmd.kind)
        htx_pkg::EM_PRE, htx_pkg::EM_CLOSE: begin
          bit_nxt     = htx_pkg::FLAG_PATTERN[bit_cnt_r];
          eof_nxt     = (cmd.kind == htx_pkg::EM_CLOSE) && sts.flag_done;
          bit_cnt_nxt = bit_cnt_r + 3'd1;
          if (bit_cnt_r == 3'd7) begin
            flag_cnt_nxt = flag_last ? 2'd0 : flag_cnt_r + 2'd1;
          end
        end
        htx_pkg::EM_SER: begin
          if (pend_r) begin
            bit_nxt  = 1'b0;
            pend_nxt = 1'b0;
            ones_nxt = 3'd0;
          end else begin
            bit_nxt     = ser_bit;
            sh_nxt      = {1'b0, sh_r[7:1]};
            bit_cnt_nxt = bit_cnt_r + 3'd1;
            if (cmd.fold_crc) begin
              crc_nxt = {1'b0, crc_r[15:1]} ^ (fb ? htx_pkg::CRC_POLY : 16'h0000);
            end
            if (ser_bit) begin
              if (ones_r == htx_pkg::STUFF_RUN - 3'd1) begin
                pend_nxt = 1'b1;
                ones_nxt = 3'd0;
              end else begin
                ones_nxt = ones_r + 3'd1;
              end
            end else begin
              ones_nxt = 3'd0;
            end
          end
        end
        htx_pkg::EM_ERR: begin
          bit_nxt = 1'b0;
          eof_nxt = 1'b1;
          err_nxt = 1'b1;
        end
        default: begin
          bit_nxt = 1'b0;
        end
      endcase
    end

    // The FCS is sent inverted, low byte first.
    if (cmd.load_fcs_lo) sh_nxt = ~crc_nxt[7:0];
    if (cmd.load_fcs_hi) sh_nxt = ~crc_r[15:8];

    if (cmd.close) begin
      crc_nxt      = htx_pkg::CRC_INIT;
      ones_nxt     = 3'd0;
      pend_nxt     = 1'b0;
      pos_nxt      = '0;
      ovf_nxt      = 1'b0;
      bit_cnt_nxt  = 3'd0;
      flag_cnt_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_cnt_r  <= 3'd1;
      clo_cnt_r  <= 2'd1;
      crc_r      <= htx_pkg::CRC_INIT;
      ones_r     <= 3'd0;
      pend_r     <= 1'b0;
      pos_r      <= '0;
      ovf_r      <= 1'b0;
      bit_cnt_r  <= 3'd0;
      flag_cnt_r <= 2'd0;
      valid_r    <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == htx_pkg::REG_PREAMBLE)) pre_cnt_r <= cfg_data;
      if (cfg_we && (cfg_index == htx_pkg::REG_CLOSING))  clo_cnt_r <= cfg_data[1:0];
      crc_r      <= crc_nxt;
      ones_r     <= ones_nxt;
      pend_r     <= pend_nxt;
      pos_r      <= pos_nxt;
      ovf_r      <= ovf_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      flag_cnt_r <= flag_cnt_nxt;
      valid_r    <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    fin_r <= fin_nxt;
    bit_r <= bit_nxt;
    eof_r <= eof_nxt;
    err_r <= err_nxt;
  end

  assign out_valid        = valid_r;
  assign out_line_bit     = bit_r;
  assign out_end_of_frame = eof_r;
  assign out_length_error = err_r;

endmodule

FILE: dv/htx_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htx_line_checker
// Watches the byte, line-bit and register-write ports of the HDLC transmit
// framer. It keeps its own framing state, builds the line bits that each
// accepted byte must produce, and compares every line-bit transfer with them
// in order.
// ----------------------------------------------------------------------------
module htx_line_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [7:0]                     in_frame_byte,
  input  logic                           in_final_byte,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_line_bit,
  input  logic                           out_end_of_frame,
  input  logic                           out_length_error,
  input  logic                           cfg_we,
  input  logic [htx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [htx_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             bits_pending,
  output int                             mismatch_count
);

  typedef struct packed {
    logic line_bit;
    logic end_of_frame;
    logic length_error;
  } line_sym_t;

  line_sym_t                   line_bits_due[$];
  logic [15:0]                 fcs_acc;
  int unsigned                 ones_seen;
  logic [htx_pkg::POS_W-1:0]   byte_pos;
  logic                        overflow_seen;
  logic [2:0]                  preamble_cnt;
  logic [1:0]                  closing_cnt;
  int                          n_due = 0;
  int                          n_bad = 0;

  assign bits_pending   = n_due;
  assign mismatch_count = n_bad;

  task automatic queue_bit(input logic lb, input logic eof, input logic err);
    line_bits_due.push_back(line_sym_t'({lb, eof, err}));
  endtask

  task automatic queue_flags(input int unsigned count, input logic mark_end);
    for (int unsigned f = 0; f < count; f++) begin
      for (int b = 0; b < 8; b++) begin
        queue_bit(htx_pkg::FLAG_PATTERN[b], mark_end && (f == count - 1) && (b == 7),
                  1'b0);
      end
    end
  endtask

  // LSB first, with a zero inserted after every run of five ones.
  task automatic queue_stuffed(input logic [7:0] v);
    for (int j = 0; j < 8; j++) begin
      queue_bit(v[j], 1'b0, 1'b0);
      if (v[j]) begin
        ones_seen++;
        if (ones_seen >= 32'(htx_pkg::STUFF_RUN)) begin
          queue_bit(1'b0, 1'b0, 1'b0);
          ones_seen = 0;
        end
      end else begin
        ones_seen = 0;
      end
    end
  endtask

  function automatic logic [15:0] crc16_x25_byte(input logic [15:0] acc,
                                                 input logic [7:0] v);
    logic [15:0] c;
    c = acc ^ {8'h00, v};
    for (int j = 0; j < 8; j++) begin
      c = c[0] ? ((c >> 1) ^ htx_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic clear_frame();
    fcs_acc       = htx_pkg::CRC_INIT;
    ones_seen     = 0;
    byte_pos      = '0;
    overflow_seen = 1'b0;
  endtask

  task automatic predict_line_bits(input logic [7:0] data, input logic fin);
    logic [7:0]                v;
    logic [htx_pkg::CNT_W-1:0] count;
    int unsigned               pre;
    int unsigned               clo;
    logic [15:0]               fcs;
    v     = data;
    count = htx_pkg::CNT_W'(byte_pos) + htx_pkg::CNT_W'(1);
    if (overflow_seen || count > htx_pkg::LEN_LIMIT) begin
      // Too long: bytes are swallowed until the final one reports the error.
      overflow_seen = 1'b1;
      if (fin) begin
        queue_bit(1'b0, 1'b1, 1'b1);
        clear_frame();
      end
    end else if (fin && count < htx_pkg::LEN_MIN) begin
      queue_bit(1'b0, 1'b1, 1'b1);
      clear_frame();
    end else begin
      if (byte_pos == htx_pkg::SSID_POS_A || byte_pos == htx_pkg::SSID_POS_B) begin
        v = (v & htx_pkg::SSID_MASK) | htx_pkg::SSID_SET;
      end
      if (byte_pos == '0) begin
        fcs_acc   = htx_pkg::CRC_INIT;
        ones_seen = 0;
        pre = 32'(preamble_cnt);
        if (pre < 1) pre = 1;
        if (pre > 4) pre = 4;
        queue_flags(pre, 1'b0);
      end
      fcs_acc = crc16_x25_byte(fcs_acc, v);
      queue_stuffed(v);
      byte_pos = count[htx_pkg::POS_W-1:0];
      if (fin) begin
        fcs = ~fcs_acc;
        queue_stuffed(fcs[7:0]);
        queue_stuffed(fcs[15:8]);
        clo = 32'(closing_cnt);
        if (clo < 1) clo = 1;
        if (clo > 2) clo = 2;
        queue_flags(clo, 1'b1);
        clear_frame();
      end
    end
  endtask

  task automatic check_line_bit();
    line_sym_t want;
    if (line_bits_due.size() == 0) begin
      n_bad++;
      $error("line_bit transfer with nothing expected: line_bit %0b eof %0b err %0b",
             out_line_bit, out_end_of_frame, out_length_error);
    end else begin
      want = line_bits_due.pop_front();
      if (out_line_bit !== want.line_bit) begin
        n_bad++;
        $error("line_bit mismatch: expected %0b, actual %0b", want.line_bit, out_line_bit);
      end
      if (out_end_of_frame !== want.end_of_frame) begin
        n_bad++;
        $error("end_of_frame mismatch: expected %0b, actual %0b",
               want.end_of_frame, out_end_of_frame);
      end
      if (out_length_error !== want.length_error) begin
        n_bad++;
        $error("length_error mismatch: expected %0b, actual %0b",
               want.length_error, out_length_error);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      preamble_cnt = 3'd1;
      closing_cnt  = 2'd1;
      clear_frame();
      line_bits_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == htx_pkg::REG_PREAMBLE) begin
          preamble_cnt = cfg_data;
        end else if (cfg_index == htx_pkg::REG_CLOSING) begin
          closing_cnt = cfg_data[1:0];
        end
      end
      if (in_valid && in_ready) predict_line_bits(in_frame_byte, in_final_byte);
      if (out_valid && out_ready) check_line_bit();
    end
    n_due = line_bits_due.size();
  end

endmodule

FILE: dv/tb_hdlc_tx_framer_crc_bitstuff.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hdlc_tx_framer_crc_bitstuff
// Drives frames of bytes into the HDLC transmit framer under a series of flag
// count settings, with random gaps and receiver stalls, and lets the line
// checker compare the stuffed bitstream, FCS and flags bit by bit.
// ----------------------------------------------------------------------------
module tb_hdlc_tx_framer_crc_bitstuff;

  // Cycles allowed after the last expected line bit before the block is
  // treated as idle; covers a byte that is swallowed without any output.
  localparam int SETTLE_CYCLES = 48;
  // Length of the one long receiver hold-off.
  localparam int HOLD_CYCLES   = 300;
  // Random frame bytes to send across the setting phases.
  localparam int unsigned RANDOM_ITEMS = 140;
  // Bytes after which a phase stops starting new frames.
  localparam int unsigned PHASE_ITEMS  = 10;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                           cfg_we;
  logic [htx_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [htx_pkg::CFG_DATA_W-1:0] cfg_data;

  htx_in_if  in_if ();
  htx_out_if out_if ();

  int bits_pending;
  int mismatch_count;

  // Idling on both sides is switched off for one calm phase.
  bit          idle_on = 1'b1;
  // Flipping this asks the receiver process for one long hold-off.
  bit          hold_toggle = 1'b0;
  int unsigned items_counted = 0;

  always #5 clk = ~clk;

  hdlc_tx_framer_crc_bitstuff u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if.sink),
    .out_chan  (out_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  htx_line_checker u_line_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_if.valid),
    .in_ready         (in_if.ready),
    .in_frame_byte    (in_if.frame_byte),
    .in_final_byte    (in_if.final_byte),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_line_bit     (out_if.line_bit),
    .out_end_of_frame (out_if.end_of_frame),
    .out_length_error (out_if.length_error),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .bits_pending     (bits_pending),
    .mismatch_count   (mismatch_count)
  );

  // Preamble and closing flag counts per phase, packed {preamble, closing}.
  // The list holds both extremes of the legal range and the out-of-range codes
  // that the block must clamp (0 and above 4 for the preamble, 0 and 3 for the
  // closing count). The closing write carries three bits; the top bit is
  // dropped by the two-bit register, so 7 acts as 3 and 4 acts as 0.
  function automatic logic [5:0] phase_setting(input int ph);
    case (ph % 8)
      0:       return {3'd4, 3'd2};
      1:       return {3'd1, 3'd1};
      2:       return {3'd0, 3'd0};
      3:       return {3'd7, 3'd7};
      4:       return {3'd2, 3'd1};
      5:       return {3'd5, 3'd2};
      6:       return {3'd3, 3'd4};
      default: return {3'd6, 3'd3};
    endcase
  endfunction

  // A legal minimum-length frame. It starts with long runs of ones across
  // byte boundaries to force stuffing, carries a flag pattern as data, and
  // puts all-zeros and 0x1F on the two SSID positions so that the forced
  // reserved bits show on the line.
  function automatic logic [7:0] directed_byte(input int i);
    case (i)
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'hFF;
      3:       return htx_pkg::FLAG_PATTERN;
      4:       return 8'hF8;
      5:       return 8'h1F;
      6:       return 8'h00;
      7:       return 8'h80;
      8:       return 8'h01;
      9:       return 8'hAA;
      10:      return 8'h55;
      11:      return 8'hFF;
      12:      return 8'hFF;
      13:      return 8'h1F;
      14:      return 8'hFF;
      default: return 8'h7F;
    endcase
  endfunction

  // One byte transfer. A random gap before the byte lowers valid for a while;
  // otherwise valid stays high straight from the previous transfer.
  task automatic send_byte(input logic [7:0] data, input logic fin);
    if (idle_on && $urandom_range(99) < 13) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.frame_byte <= data;
    in_if.final_byte <= fin;
    do @(posedge clk); while (!(in_if.valid === 1'b1 && in_if.ready === 1'b1));
  endtask

  // A frame of random bytes. Bytes are skewed toward all-ones and the flag
  // value so that bit stuffing is hit often. Bytes past the length limit are
  // swallowed by the block and are not counted as stimulus.
  task automatic send_frame(input int unsigned len);
    logic [7:0] data;
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0, 1, 2: data = 8'hFF;
        3:       data = htx_pkg::FLAG_PATTERN;
        4:       data = 8'h00;
        default: data = 8'($urandom_range(255));
      endcase
      send_byte(data, i == len - 1);
      if (i < htx_pkg::LEN_LIMIT) items_counted++;
    end
  endtask

  // Stops offering bytes and waits until every predicted line bit has been
  // transferred, then lets the block settle. The pending count is sampled on
  // the falling edge so that it never races the checker's update.
  task automatic wait_line_idle();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (bits_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; the enable drops between writes.
  task automatic write_reg(input logic [htx_pkg::CFG_IDX_W-1:0] idx,
                           input logic [htx_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver. Stalls at random while idling is on, and once holds ready low
  // for a long stretch so that the framer fills up and backs up its input.
  initial begin
    bit seen_toggle;
    int hold_left;
    seen_toggle  = 1'b0;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle != seen_toggle) begin
        seen_toggle = hold_toggle;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(idle_on && $urandom_range(99) < 13);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int          ph;
    int unsigned phase_start;
    int unsigned len;
    logic [5:0]  setting;

    in_if.valid      = 1'b0;
    in_if.frame_byte = 8'h00;
    in_if.final_byte = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at the reset flag counts of one and one. A frame of a
    // single byte is too short: it must give the error transfer only, with no
    // preamble before it. Then one legal frame of the minimum length.
    send_byte(8'hFF, 1'b1);
    for (int i = 0; i < 16; i++) begin
      send_byte(directed_byte(i), i == 15);
    end
    wait_line_idle();

    // Random part. Each phase writes both flag counts while the framer is
    // idle, then sends frames, mostly of legal length with some that are too
    // short. Phase 2 runs with no idling at all; phase 4 starts the long
    // receiver hold-off while the sender keeps offering bytes. Every phase
    // ends with the sender paused until all line bits have come out.
    ph = 0;
    while (ph < 8 || items_counted < RANDOM_ITEMS) begin
      setting = phase_setting(ph);
      write_reg(htx_pkg::REG_PREAMBLE, setting[5:3]);
      write_reg(htx_pkg::REG_CLOSING, setting[2:0]);
      idle_on = (ph != 2);
      if (ph == 4) hold_toggle = ~hold_toggle;
      phase_start = items_counted;
      while (items_counted - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(5) == 0) begin
          len = $urandom_range(1, 15);
        end else begin
          len = $urandom_range(16, 20);
        end
        send_frame(len);
      end
      wait_line_idle();
      ph++;
    end

    // Length boundary at the widest flag settings: one byte short of the
    // minimum.
    idle_on = 1'b1;
    write_reg(htx_pkg::REG_PREAMBLE, 3'd4);
    write_reg(htx_pkg::REG_CLOSING, 3'd2);
    send_frame(15);
    wait_line_idle();

    if (mismatch_count == 0) begin
      $display("hdlc_tx_framer_crc_bitstuff test passed");
    end else begin
      $display("hdlc_tx_framer_crc_bitstuff test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #1ms;
    $display("hdlc_tx_framer_crc_bitstuff test failed");
    $finish;
  end

endmodule
